// ----- src/assert_macros.svh -----
// Assertion macros shared by the peak detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PDHW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PDHW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pdhw_pkg.sv -----
// Package: types, constants and helpers of the peak detector.
`timescale 1ns / 1ps
package pdhw_pkg;

    localparam int IndexBits = 16;
    localparam int SampleBits = 16;
    localparam int HoldBits = 10;
    localparam int PeakBits = 8;
    localparam int CfgIndexBits = 2;
    localparam int CfgDataBits = 16;

    // configuration register indexes
    localparam logic [CfgIndexBits-1:0] CfgThreshold = 2'd0;
    localparam logic [CfgIndexBits-1:0] CfgHoldLength = 2'd1;
    localparam logic [CfgIndexBits-1:0] CfgMaxPeaks = 2'd2;

    localparam logic signed [SampleBits-1:0] ThresholdReset = 16'sd256;
    localparam logic [HoldBits-1:0] HoldLengthReset = 10'd150;
    localparam logic [PeakBits-1:0] MaxPeaksReset = 8'd50;
    localparam logic [HoldBits-1:0] HoldCountMax = '1;
    localparam logic [PeakBits-1:0] PeaksMax = '1;

    typedef struct packed {
        logic [SampleBits-1:0] sample;
        logic                  record_start;
    } t_in_item;

    // low 16 bits of a sample index, zero-extended when the index is narrower
    function automatic logic [15:0] to_peak_index(input logic [IndexBits-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[15:0];
    endfunction

endpackage

// ----- src/pdhw_in_if.sv -----
// Sample channel: valid/ready handshake with one sample beat.
`timescale 1ns / 1ps
interface pdhw_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        record_start;

    modport source (output valid, output sample, output record_start, input ready);
    modport sink (input valid, input sample, input record_start, output ready);
endinterface

// ----- src/pdhw_out_if.sv -----
// Peak report channel: valid/ready handshake with one report beat.
`timescale 1ns / 1ps
interface pdhw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] peak_index;
    logic [15:0] peak_level;
    logic [7:0]  peak_number;

    modport source (output valid, output peak_index, output peak_level,
                    output peak_number, input ready);
    modport sink (input valid, input peak_index, input peak_level,
                  input peak_number, output ready);
endinterface

// ----- src/pdhw_in_stage.sv -----
// Input register stage: holds one sample beat until the core takes it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pdhw_in_stage
    import pdhw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdhw_in_if.sink     i_samp,
    input  logic        i_advance,
    output logic        o_valid,
    output t_in_item    o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    // refill in the same cycle the core drains the register
    assign i_samp.ready = !r_valid || i_advance;
    assign accept = i_samp.valid && i_samp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.sample <= i_samp.sample;
            r_item.record_start <= i_samp.record_start;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;

    `PDHW_ASSERT_NEXT(a_accept_fills, accept, r_valid, "accepted beat not registered")
    `PDHW_ASSERT_NEXT(a_stall_keeps, r_valid && !i_advance, r_valid,
                      "held beat dropped without advance")

endmodule

// ----- src/pdhw_core.sv -----
// Peak judging core: detector state, config registers and report register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pdhw_core
    import pdhw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CfgIndexBits-1:0] i_cfg_index,
    input  logic [CfgDataBits-1:0]  i_cfg_data,
    input  logic                    i_valid,
    input  t_in_item                i_item,
    output logic                    o_advance,
    pdhw_out_if.source              o_peak
);

    typedef enum logic [1:0] {
        ST_EMPTY,
        ST_ONE,
        ST_FULL
    } t_fill;

    t_fill r_fill, n_fill;

    logic signed [SampleBits-1:0] r_threshold;
    logic [HoldBits-1:0]          r_hold_length;
    logic [PeakBits-1:0]          r_max_peaks;

    logic signed [SampleBits-1:0] r_before, n_before;
    logic signed [SampleBits-1:0] r_center, n_center;
    logic signed [SampleBits-1:0] r_ref, n_ref;
    logic [IndexBits-1:0]         r_seen, n_seen;
    logic [IndexBits-1:0]         r_kept_index, n_kept_index;
    logic signed [SampleBits-1:0] r_kept_level, n_kept_level;
    logic                         r_hold_active, n_hold_active;
    logic [HoldBits-1:0]          r_hold_count, n_hold_count;
    logic [PeakBits-1:0]          r_peaks, n_peaks;

    logic                  r_out_valid;
    logic [15:0]           r_out_index;
    logic [SampleBits-1:0] r_out_level;
    logic [PeakBits-1:0]   r_out_number;

    logic                         advance;
    logic                         emit;
    logic                         cand;
    logic signed [SampleBits-1:0] x;

    assign advance = i_valid && (!r_out_valid || o_peak.ready);
    assign o_advance = advance;
    assign x = i_item.sample;

    always_comb begin
        n_fill = r_fill;
        n_before = r_before;
        n_center = r_center;
        n_ref = r_ref;
        n_seen = r_seen;
        n_kept_index = r_kept_index;
        n_kept_level = r_kept_level;
        n_hold_active = r_hold_active;
        n_hold_count = r_hold_count;
        n_peaks = r_peaks;
        emit = 1'b0;
        cand = 1'b0;
        if (i_item.record_start || r_fill == ST_EMPTY) begin
            n_before = '0;
            n_center = x;
            n_ref = x;
            n_seen = IndexBits'(1);
            n_kept_index = '0;
            n_kept_level = '0;
            n_hold_active = 1'b0;
            n_hold_count = '0;
            n_peaks = '0;
            n_fill = ST_ONE;
        end else begin
            if (r_fill == ST_FULL) begin
                // reference follows the predecessor unless the center sits on a flat
                if (r_center != x && r_center != r_before) begin
                    n_ref = r_before;
                end
                cand = (r_center > n_ref) && (r_center > x) && (r_center > r_threshold)
                       && (r_peaks < r_max_peaks);
                if (cand) begin
                    if (!r_hold_active || r_center >= r_kept_level) begin
                        n_kept_index = r_seen - IndexBits'(1);
                        n_kept_level = r_center;
                    end
                    n_hold_active = 1'b1;
                    n_hold_count = '0;
                end
                if (n_hold_active) begin
                    if (n_hold_count != HoldCountMax) begin
                        n_hold_count = n_hold_count + HoldBits'(1);
                    end
                    if (n_hold_count == r_hold_length) begin
                        emit = 1'b1;
                        if (r_peaks != PeaksMax) begin
                            n_peaks = r_peaks + PeakBits'(1);
                        end
                        n_hold_active = 1'b0;
                        n_hold_count = '0;
                    end
                end
            end
            n_before = r_center;
            n_center = x;
            n_seen = r_seen + IndexBits'(1);
            n_fill = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= ST_EMPTY;
            r_threshold <= ThresholdReset;
            r_hold_length <= HoldLengthReset;
            r_max_peaks <= MaxPeaksReset;
            r_before <= '0;
            r_center <= '0;
            r_ref <= '0;
            r_seen <= '0;
            r_kept_index <= '0;
            r_kept_level <= '0;
            r_hold_active <= 1'b0;
            r_hold_count <= '0;
            r_peaks <= '0;
            r_out_valid <= 1'b0;
            r_out_index <= '0;
            r_out_level <= '0;
            r_out_number <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CfgThreshold:  r_threshold <= i_cfg_data;
                    CfgHoldLength: r_hold_length <= i_cfg_data[HoldBits-1:0];
                    CfgMaxPeaks:   r_max_peaks <= i_cfg_data[PeakBits-1:0];
                    default: ;
                endcase
            end
            if (advance) begin
                r_fill <= n_fill;
                r_before <= n_before;
                r_center <= n_center;
                r_ref <= n_ref;
                r_seen <= n_seen;
                r_kept_index <= n_kept_index;
                r_kept_level <= n_kept_level;
                r_hold_active <= n_hold_active;
                r_hold_count <= n_hold_count;
                r_peaks <= n_peaks;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
                r_out_index <= to_peak_index(n_kept_index);
                r_out_level <= n_kept_level;
                r_out_number <= r_peaks;
            end else if (o_peak.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_peak.valid = r_out_valid;
    assign o_peak.peak_index = r_out_index;
    assign o_peak.peak_level = r_out_level;
    assign o_peak.peak_number = r_out_number;

    `PDHW_ASSERT_NOW(a_idle_hold_clear, !r_hold_active, r_hold_count == '0,
                     "hold count running without an active hold")
    `PDHW_ASSERT_NOW(a_emit_needs_full, advance && emit, r_fill == ST_FULL,
                     "report raised before a center was held")
    `PDHW_ASSERT_NOW(a_no_overwrite, r_out_valid && !o_peak.ready, !advance,
                     "core advanced over an untaken report")

endmodule

// ----- src/peak_detector_hold_window.sv -----
// Top level of the peak detector with hold window.
`timescale 1ns / 1ps
// Finds local maxima in a stream of signed Q8.8 samples split into records.
// One sample is taken every cycle unless report backpressure holds the core: a
// sample beat lands in the input register, and when the core advances it judges
// the previous center against it, updates the hold state and loads any report
// beat into the result register. The rate is bounded only by the single
// register-to-register judging step and by report backpressure: while a report
// waits on o_peak, the core stops and the input register fills. Write
// threshold, hold_length and max_peaks through the cfg port only when no
// sample is in flight. Sample indices wrap at 2^16.
module peak_detector_hold_window
    import pdhw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CfgIndexBits-1:0] i_cfg_index,
    input  logic [CfgDataBits-1:0]  i_cfg_data,
    pdhw_in_if.sink                 i_samp,
    pdhw_out_if.source              o_peak
);

    logic     stage_valid;
    t_in_item stage_item;
    logic     advance;

    pdhw_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_samp    (i_samp),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    pdhw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_advance   (advance),
        .o_peak      (o_peak)
    );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the peak detector with hold window.
`timescale 1ns / 1ps
module tb_top;
    import pdhw_pkg::*;

    typedef enum logic [1:0] {FillEmpty, FillFirst, FillFull} t_fill;

    typedef struct packed {
        logic [15:0] index;
        logic [15:0] level;
        logic [7:0]  number;
    } t_peak_rpt;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CfgIndexBits-1:0] i_cfg_index = CfgThreshold;
    logic [CfgDataBits-1:0]  i_cfg_data = '0;

    pdhw_in_if  samp_ch();
    pdhw_out_if peak_ch();

    peak_detector_hold_window dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_samp      (samp_ch),
        .o_peak      (peak_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and its copy of the registers
    logic signed [15:0] thr_cfg = ThresholdReset;
    logic [9:0]         hold_cfg = HoldLengthReset;
    logic [7:0]         maxp_cfg = MaxPeaksReset;

    logic signed [15:0] prev_lvl = '0;
    logic signed [15:0] ctr_lvl = '0;
    logic signed [15:0] ref_lvl = '0;
    logic signed [15:0] kept_lvl = '0;
    logic [15:0]        seen_cnt = '0;
    logic [15:0]        kept_idx = '0;
    logic               hold_on = 1'b0;
    logic [9:0]         hold_cnt = '0;
    logic [7:0]         npeaks = '0;
    t_fill              fill = FillEmpty;

    t_in_item  feed_q[$];
    t_peak_rpt pending_peaks[$];
    int        beats_queued = 0;
    int        beats_taken = 0;
    int        mismatch_cnt = 0;
    bit        idle_on = 1'b1;

    // Judge the held center against the new sample and queue any report it triggers.
    function automatic void judge_beat(input t_in_item b);
        logic signed [15:0] x;
        logic signed [15:0] c;
        logic [15:0]        idx;
        x = $signed(b.sample);
        if (b.record_start || fill == FillEmpty) begin
            prev_lvl = '0;
            ctr_lvl = x;
            ref_lvl = x;
            seen_cnt = 16'd1;
            kept_idx = '0;
            kept_lvl = '0;
            hold_on = 1'b0;
            hold_cnt = '0;
            npeaks = '0;
            fill = FillFirst;
            return;
        end
        if (fill == FillFull) begin
            c = ctr_lvl;
            idx = seen_cnt - 16'd1;
            if (c != x && c != prev_lvl)
                ref_lvl = prev_lvl;
            if (c > ref_lvl && c > x && c > thr_cfg && npeaks < maxp_cfg) begin
                if (!hold_on || c >= kept_lvl) begin
                    kept_idx = idx;
                    kept_lvl = c;
                end
                hold_on = 1'b1;
                hold_cnt = '0;
            end
            if (hold_on) begin
                if (hold_cnt != HoldCountMax)
                    hold_cnt++;
                // a zero hold length never matches here, so the hold runs until the record restarts
                if (hold_cnt == hold_cfg) begin
                    pending_peaks.push_back('{kept_idx, kept_lvl, npeaks});
                    if (npeaks != PeaksMax)
                        npeaks++;
                    hold_on = 1'b0;
                    hold_cnt = '0;
                end
            end
        end
        prev_lvl = ctr_lvl;
        ctr_lvl = x;
        seen_cnt++;
        fill = FillFull;
    endfunction

    function automatic void add_beat(input logic [15:0] lvl, input logic start);
        feed_q.push_back('{lvl, start});
        beats_queued++;
    endfunction

    function automatic logic [15:0] pick_level(input int mode, input logic signed [15:0] last);
        int v;
        case (mode)
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: begin
                v = int'(last) + int'($urandom_range(0, 1200)) - 600;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
            2: v = (int'($urandom_range(0, 3)) - 1) * 256;
            default: v = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 32767))
                                                     : int'($urandom_range(0, 64)) - 32;
        endcase
        return 16'(v);
    endfunction

    task automatic program_limits(input logic signed [15:0] thr, input logic [9:0] hold,
                                  input logic [7:0] maxp);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CfgThreshold;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_index <= CfgHoldLength;
        i_cfg_data <= 16'(hold);
        @(posedge i_clk);
        i_cfg_index <= CfgMaxPeaks;
        i_cfg_data <= 16'(maxp);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        thr_cfg = thr;
        hold_cfg = hold;
        maxp_cfg = maxp;
    endtask

    // Sender holds off until every beat is taken and every report is back.
    task automatic wait_quiet();
        while (beats_taken != beats_queued || pending_peaks.size() != 0)
            @(posedge i_clk);
        // beats with no report may still sit in the input register or the core
        repeat (6) @(posedge i_clk);
    endtask

    task automatic add_records(input int n);
        int               left;
        int               len;
        int               mode;
        logic signed [15:0] lvl;
        left = n;
        lvl = '0;
        while (left > 0) begin
            len = $urandom_range(1, 60);
            if (len > left) len = left;
            mode = $urandom_range(0, 3);
            for (int k = 0; k < len; k++) begin
                lvl = pick_level(mode, lvl);
                // now and then a record runs on without its start flag
                add_beat(lvl, (k == 0) && ($urandom_range(0, 7) != 0));
            end
            left -= len;
        end
    endtask

    task automatic log_bad(input string why, input t_peak_rpt want, input t_peak_rpt got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t %s: exp idx %0d lvl %0d num %0d, got idx %0d lvl %0d num %0d",
                     $time, why, want.index, $signed(want.level), want.number,
                     got.index, $signed(got.level), got.number);
    endtask

    // sample driver
    int       gap_left = 0;
    t_in_item next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            samp_ch.valid <= 1'b0;
        end else begin
            if (samp_ch.valid && samp_ch.ready) begin
                judge_beat('{samp_ch.sample, samp_ch.record_start});
                beats_taken++;
            end
            if (!samp_ch.valid || samp_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    samp_ch.valid <= 1'b0;
                end else if (feed_q.size() != 0) begin
                    next_beat = feed_q.pop_front();
                    samp_ch.valid <= 1'b1;
                    samp_ch.sample <= next_beat.sample;
                    samp_ch.record_start <= next_beat.record_start;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 5);
                end else begin
                    samp_ch.valid <= 1'b0;
                end
            end
        end
    end

    // report monitor
    int stall_left = 0;

    always @(posedge i_clk) begin : report_mon
        t_peak_rpt got;
        t_peak_rpt want;
        if (!i_rst_n) begin
            peak_ch.ready <= 1'b0;
        end else begin
            if (peak_ch.valid && peak_ch.ready) begin
                got = '{peak_ch.peak_index, peak_ch.peak_level, peak_ch.peak_number};
                if (pending_peaks.size() == 0) begin
                    log_bad("unexpected peak report", '0, got);
                end else begin
                    want = pending_peaks.pop_front();
                    if (got.index !== want.index || got.level !== want.level ||
                        got.number !== want.number)
                        log_bad("peak report mismatch", want, got);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                peak_ch.ready <= 1'b0;
            end else begin
                peak_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 5);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        samp_ch.valid = 1'b0;
        samp_ch.sample = '0;
        samp_ch.record_start = 1'b0;
        peak_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // widest threshold, report on the same judged sample that makes a candidate
        program_limits(16'sh8000, 10'd1, 8'd255);
        add_beat(16'h8000, 1'b0);    // first beat after reset opens a record by itself
        add_beat(16'h7fff, 1'b0);
        add_beat(16'h8000, 1'b0);
        add_beat(16'd300, 1'b0);
        add_beat(16'd300, 1'b0);     // plateau, yet no peak: the reference still holds 32767
        add_beat(16'd200, 1'b0);
        add_beat(16'd500, 1'b0);
        add_beat(16'd400, 1'b0);
        add_beat(16'd400, 1'b0);
        add_beat(16'h7fff, 1'b1);
        add_beat(16'd0, 1'b0);
        add_beat(16'h7fff, 1'b0);
        add_beat(16'hffff, 1'b0);
        wait_quiet();

        // threshold at the top: nothing can qualify
        program_limits(16'sh7fff, 10'd1023, 8'd1);
        add_beat(16'h7fff, 1'b1);
        add_beat(16'h8000, 1'b0);
        add_beat(16'h7fff, 1'b0);
        add_beat(16'd0, 1'b0);
        wait_quiet();

        // zero hold length: holds never expire and die at the record start
        program_limits(16'sd0, 10'd0, 8'd255);
        add_beat(16'd10, 1'b1);
        add_beat(16'd900, 1'b0);
        add_beat(16'd5, 1'b0);
        add_beat(16'd700, 1'b0);
        add_beat(16'd1, 1'b0);
        add_beat(16'd3, 1'b1);
        wait_quiet();

        // zero peak budget
        program_limits(16'sd0, 10'd1, 8'd0);
        add_beat(16'd0, 1'b1);
        add_beat(16'd800, 1'b0);
        add_beat(16'd0, 1'b0);
        wait_quiet();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: program_limits(16'(int'($urandom_range(0, 1024)) - 512), 10'd1, 8'd1);
                1: program_limits(16'(int'($urandom_range(0, 1024)) - 512),
                                  10'($urandom_range(2, 8)), 8'($urandom_range(1, 4)));
                2: program_limits(16'sh8000, 10'd3, 8'd255);
                3: program_limits(16'sh7fff, 10'd1023, 8'd255);
                4: program_limits(16'(int'($urandom_range(0, 1024)) - 512), 10'd0, 8'd3);
                5: program_limits(16'(int'($urandom_range(0, 1024)) - 512),
                                  10'($urandom_range(1, 10)), 8'd0);
                default: program_limits(16'(int'($urandom_range(0, 1024)) - 512),
                                        10'($urandom_range(1, 12)), 8'($urandom_range(1, 8)));
            endcase
            add_records(45);
            wait_quiet();
        end

        // zigzag record at full rate: a candidate every other sample runs the budget out
        idle_on = 1'b0;
        program_limits(16'sh8000, 10'd1, 8'd20);
        for (int k = 0; k < 120; k++) begin
            if (k % 2 == 1)
                add_beat(16'($urandom_range(0, 32767)), 1'b0);
            else
                add_beat(16'(int'($urandom_range(0, 32767)) - 32768), k == 0);
        end
        wait_quiet();
        repeat (10) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
